// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define P2G_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p2g assertion failed");

// next-cycle implication
`define P2G_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p2g assertion failed");

`endif

// File: rtl/p2g_pkg.sv
// ---------------------------------------------------------------------------
// p2g_pkg
// Types and constants of the pixel to ground plane block.
// ---------------------------------------------------------------------------
package p2g_pkg;

  localparam int COEF_W    = 48;
  localparam int PIX_W     = 16;
  localparam int OUT_W     = 32;
  localparam int OUT_FRAC  = 8;
  localparam int PROD_W    = 65;
  localparam int SUM_W     = 66;
  localparam int NUM_W     = SUM_W + OUT_FRAC;
  localparam int QB        = OUT_W + 1;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_X_U   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_V   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ONE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_U   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_V   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ONE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_W_U   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_W_V   = 4'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_u;
    logic [PIX_W-1:0] pixel_v;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic                    point_valid;
  } out_item_t;

  typedef struct packed {
    logic             zero;
    logic             neg_x;
    logic             neg_y;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [SUM_W-1:0] den;
  } div_in_t;

endpackage

// File: rtl/p2g_div.sv
// ---------------------------------------------------------------------------
// p2g_div
// Pipelined restoring divider for both coordinates, one quotient bit per
// stage, with range check and saturation.
// ---------------------------------------------------------------------------
module p2g_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  p2g_pkg::div_in_t    in_data,
  output logic                out_strobe,
  output p2g_pkg::out_item_t  out_item
);
  import p2g_pkg::*;

  typedef struct packed {
    logic             zero;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic [SUM_W-1:0] rem_x;
    logic [SUM_W-1:0] rem_y;
    logic [QB-1:0]    low_x;
    logic [QB-1:0]    low_y;
    logic [QB-1:0]    q_x;
    logic [QB-1:0]    q_y;
    logic [SUM_W-1:0] den;
  } step_t;

  logic      vld_r [QB+1];
  step_t     st_r  [QB+1];
  step_t     st_nxt [QB+1];
  logic      out_strobe_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  function automatic logic [OUT_W-1:0] sat(input logic ovf, input logic neg,
                                           input logic [QB-1:0] q);
    if (neg) begin
      if (ovf || q > {1'b0, 1'b1, {(OUT_W-1){1'b0}}}) begin
        sat = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        sat = OUT_W'({QB{1'b0}} - q);
      end
    end else begin
      if (ovf || q > {2'b00, {(OUT_W-1){1'b1}}}) begin
        sat = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        sat = q[OUT_W-1:0];
      end
    end
  endfunction

  always_comb begin
    logic [SUM_W:0] tx;
    logic [SUM_W:0] ty;
    tx = '0;
    ty = '0;
    st_nxt[0].zero  = in_data.zero;
    st_nxt[0].neg_x = in_data.neg_x;
    st_nxt[0].neg_y = in_data.neg_y;
    st_nxt[0].ovf_x = {{(SUM_W+QB-NUM_W){1'b0}}, in_data.num_x} >= {in_data.den, {QB{1'b0}}};
    st_nxt[0].ovf_y = {{(SUM_W+QB-NUM_W){1'b0}}, in_data.num_y} >= {in_data.den, {QB{1'b0}}};
    st_nxt[0].rem_x = SUM_W'(in_data.num_x[NUM_W-1:QB]);
    st_nxt[0].rem_y = SUM_W'(in_data.num_y[NUM_W-1:QB]);
    st_nxt[0].low_x = in_data.num_x[QB-1:0];
    st_nxt[0].low_y = in_data.num_y[QB-1:0];
    st_nxt[0].q_x   = '0;
    st_nxt[0].q_y   = '0;
    st_nxt[0].den   = in_data.den;
    for (int k = 0; k < QB; k++) begin
      st_nxt[k+1] = st_r[k];
      tx = {st_r[k].rem_x, st_r[k].low_x[QB-1]};
      ty = {st_r[k].rem_y, st_r[k].low_y[QB-1]};
      if (tx >= {1'b0, st_r[k].den}) begin
        tx = tx - {1'b0, st_r[k].den};
        st_nxt[k+1].q_x = {st_r[k].q_x[QB-2:0], 1'b1};
      end else begin
        st_nxt[k+1].q_x = {st_r[k].q_x[QB-2:0], 1'b0};
      end
      if (ty >= {1'b0, st_r[k].den}) begin
        ty = ty - {1'b0, st_r[k].den};
        st_nxt[k+1].q_y = {st_r[k].q_y[QB-2:0], 1'b1};
      end else begin
        st_nxt[k+1].q_y = {st_r[k].q_y[QB-2:0], 1'b0};
      end
      st_nxt[k+1].rem_x = tx[SUM_W-1:0];
      st_nxt[k+1].rem_y = ty[SUM_W-1:0];
      st_nxt[k+1].low_x = {st_r[k].low_x[QB-2:0], 1'b0};
      st_nxt[k+1].low_y = {st_r[k].low_y[QB-2:0], 1'b0};
    end
  end

  always_comb begin
    if (st_r[QB].zero) begin
      out_item_nxt = '0;
    end else begin
      out_item_nxt.world_x     = sat(st_r[QB].ovf_x, st_r[QB].neg_x, st_r[QB].q_x);
      out_item_nxt.world_y     = sat(st_r[QB].ovf_y, st_r[QB].neg_y, st_r[QB].q_y);
      out_item_nxt.point_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_strobe_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < QB; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      out_strobe_r <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QB; k++) begin
      st_r[k] <= st_nxt[k];
    end
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`include "assert_macros.svh"

  `P2G_ASSERT_IMP(a_zero_out, out_strobe_r && !out_item_r.point_valid, out_item_r.world_x == '0 && out_item_r.world_y == '0)
  `P2G_ASSERT_NXT(a_pos_sign, vld_r[QB] && !st_r[QB].zero && !st_r[QB].neg_x, !out_item_r.world_x[OUT_W-1])
  `P2G_ASSERT_NXT(a_valid_flow, vld_r[0], vld_r[1])

endmodule

// File: rtl/pixel_to_ground_plane.sv
// ---------------------------------------------------------------------------
// pixel_to_ground_plane
// Maps an image point onto the ground plane through an eight-coefficient
// homography: x = (a*u+b*v+c)/w, y = (d*u+e*v+f)/w, w = g*u+h*v+1.
// ---------------------------------------------------------------------------
// One item per cycle, busy is always low. Each item gives one result,
// strobed on out_strobe after passing the multiply, sum and magnitude
// registers, a range check register, 33 divider stages (one quotient bit
// each, both coordinates in parallel) and the saturating output register.
// Results cannot be held off. Coefficients must be written only while no
// item is in flight; the block itself does not enforce this.
module pixel_to_ground_plane #(
  parameter int COEF_FRAC_BITS  = 32,
  parameter int PIXEL_FRAC_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  p2g_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [p2g_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [p2g_pkg::COEF_W-1:0]          cfg_data,
  output logic                                out_strobe,
  output p2g_pkg::out_item_t                  out_item
);
  import p2g_pkg::*;

  localparam logic [COEF_W-1:0] COEF_UNIT = COEF_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] W_ONE =
    SUM_W'(66'd1 << (COEF_FRAC_BITS + PIXEL_FRAC_BITS));

  logic signed [COEF_W-1:0] coef_r [NUM_CFG];
  logic                     v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0] p_r [6];
  logic signed [SUM_W-1:0]  nx_r, ny_r, w_r;
  logic signed [SUM_W-1:0]  nx_nxt, ny_nxt, w_nxt;
  div_in_t                  d_r, d_nxt;
  logic [SUM_W-1:0]         mx, my;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        coef_r[i] <= (i == CFG_X_U || i == CFG_Y_V) ? COEF_UNIT : '0;
      end
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
        coef_r[cfg_index[2:0]] <= cfg_data;
      end
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= coef_r[CFG_X_U[2:0]] * $signed({1'b0, in_item.pixel_u});
    p_r[1] <= coef_r[CFG_X_V[2:0]] * $signed({1'b0, in_item.pixel_v});
    p_r[2] <= coef_r[CFG_Y_U[2:0]] * $signed({1'b0, in_item.pixel_u});
    p_r[3] <= coef_r[CFG_Y_V[2:0]] * $signed({1'b0, in_item.pixel_v});
    p_r[4] <= coef_r[CFG_W_U[2:0]] * $signed({1'b0, in_item.pixel_u});
    p_r[5] <= coef_r[CFG_W_V[2:0]] * $signed({1'b0, in_item.pixel_v});
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    w_r    <= w_nxt;
    d_r    <= d_nxt;
  end

  always_comb begin
    nx_nxt = SUM_W'(p_r[0]) + SUM_W'(p_r[1]) +
             (SUM_W'(coef_r[CFG_X_ONE[2:0]]) <<< PIXEL_FRAC_BITS);
    ny_nxt = SUM_W'(p_r[2]) + SUM_W'(p_r[3]) +
             (SUM_W'(coef_r[CFG_Y_ONE[2:0]]) <<< PIXEL_FRAC_BITS);
    w_nxt  = SUM_W'(p_r[4]) + SUM_W'(p_r[5]) + W_ONE;
  end

  always_comb begin
    mx = nx_r[SUM_W-1] ? SUM_W'(-nx_r) : SUM_W'(nx_r);
    my = ny_r[SUM_W-1] ? SUM_W'(-ny_r) : SUM_W'(ny_r);
    d_nxt.zero  = (w_r == '0);
    d_nxt.neg_x = nx_r[SUM_W-1] ^ w_r[SUM_W-1];
    d_nxt.neg_y = ny_r[SUM_W-1] ^ w_r[SUM_W-1];
    d_nxt.num_x = {mx, {OUT_FRAC{1'b0}}};
    d_nxt.num_y = {my, {OUT_FRAC{1'b0}}};
    d_nxt.den   = w_r[SUM_W-1] ? SUM_W'(-w_r) : SUM_W'(w_r);
  end

  assign busy = 1'b0;

  p2g_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (v3_r),
    .in_data    (d_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
